// ----- rtl/core/catmull_rom_spline_eval_top_defines.svh -----
// assertion macros shared by the spline evaluator rtl
// no dependencies
`ifndef CATMULL_ROM_SPLINE_EVAL_TOP_DEFINES_SVH
`define CATMULL_ROM_SPLINE_EVAL_TOP_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define CRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define CRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/crs_pkg.sv -----
// types and constants of the catmull-rom spline evaluator
// no dependencies
`default_nettype none
package crs_pkg;
  localparam int COORD_W = 24;
  localparam int GRAD_W  = 28;
  localparam int T_W     = 22;
  localparam int NUM_W   = 7;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic CFG_NUM_POINTS  = 1'b0;
  localparam logic CFG_LOOPED_MODE = 1'b1;

  typedef struct packed {
    logic                      command;
    logic [5:0]                point_index;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [T_W-1:0]            param_t;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [GRAD_W-1:0]  grad_x;
    logic signed [GRAD_W-1:0]  grad_y;
    logic                      out_of_range;
  } out_item_t;
endpackage
`default_nettype wire

// ----- rtl/core/crs_point_mem.sv -----
// four-bank control point memory, one bank per spline tap
// depends on crs_pkg and the defines header
`default_nettype none
`include "catmull_rom_spline_eval_top_defines.svh"
module crs_point_mem #(
  parameter int MAX_POINTS = 64,
  parameter int IDX_W      = 6
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               wr_en,
  input  wire logic [IDX_W-1:0]                   wr_idx,
  input  wire logic signed [crs_pkg::COORD_W-1:0] wr_x,
  input  wire logic signed [crs_pkg::COORD_W-1:0] wr_y,
  input  wire logic [3:0][IDX_W-1:0]              rd_idx,
  output      logic [3:0][crs_pkg::COORD_W-1:0]   rd_x,
  output      logic [3:0][crs_pkg::COORD_W-1:0]   rd_y
);
  // every bank takes every write, so each tap reads on its own port
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [2*crs_pkg::COORD_W-1:0] mem [MAX_POINTS];
    logic [2*crs_pkg::COORD_W-1:0] q_r;
    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_idx] <= {wr_x, wr_y};
      end
      q_r <= mem[rd_idx[b]];
    end
    assign rd_x[b] = q_r[2*crs_pkg::COORD_W-1:crs_pkg::COORD_W];
    assign rd_y[b] = q_r[crs_pkg::COORD_W-1:0];
  end

  `CRS_ASSERT(a_wr_idx_known, !wr_en || !$isunknown(wr_idx), "write index unknown")
  `CRS_ASSERT(a_wr_in_table, !wr_en || (int'(wr_idx) < MAX_POINTS), "write beyond table")
  `CRS_ASSERT(a_rd_in_table, (int'(rd_idx[0]) < MAX_POINTS) && (int'(rd_idx[3]) < MAX_POINTS),
              "read beyond table")
endmodule
`default_nettype wire

// ----- rtl/core/crs_blend.sv -----
// weight generation and four-tap blend pipeline with rounding and saturation
// depends on crs_pkg
`default_nettype none
module crs_blend #(
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_vld,
  input  wire logic                             in_oor,
  input  wire logic [T_FRAC_BITS-1:0]           in_frac,
  input  wire logic [3:0][crs_pkg::COORD_W-1:0] px,
  input  wire logic [3:0][crs_pkg::COORD_W-1:0] py,
  input  wire logic                             px_vld,
  output      logic                             out_vld,
  output      crs_pkg::out_item_t               out_item
);
  localparam int FW = T_FRAC_BITS;
  localparam int WW = FW + 6;
  localparam int PW = crs_pkg::COORD_W + WW;
  localparam int SW = PW + 3;

  // stage a: tt
  logic [FW-1:0] f_a_r, tt_a_r;
  logic          v_a_r, o_a_r;
  logic [2*FW-1:0] sq;
  assign sq = {{FW{1'b0}}, in_frac} * {{FW{1'b0}}, in_frac};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else begin
      v_a_r <= in_vld;
    end
    o_a_r  <= in_oor;
    f_a_r  <= in_frac;
    tt_a_r <= sq[2*FW-1:FW];
  end

  // stage b: ttt and weights
  logic [2*FW-1:0] cu;
  logic signed [WW-1:0] f_s, t2, t3, one_s;
  logic signed [3:0][WW-1:0] wq_nxt, wg_nxt, wq_r, wg_r;
  logic v_b_r, o_b_r;
  assign cu    = {{FW{1'b0}}, tt_a_r} * {{FW{1'b0}}, f_a_r};
  assign f_s   = WW'(f_a_r);
  assign t2    = WW'(tt_a_r);
  assign t3    = WW'(cu[2*FW-1:FW]);
  assign one_s = WW'(1) <<< FW;
  always_comb begin
    wq_nxt[0] = WW'(-t3 + 2 * t2 - f_s);
    wq_nxt[1] = WW'(3 * t3 - 5 * t2 + 2 * one_s);
    wq_nxt[2] = WW'(-3 * t3 + 4 * t2 + f_s);
    wq_nxt[3] = WW'(t3 - t2);
    wg_nxt[0] = WW'(-3 * t2 + 4 * f_s - one_s);
    wg_nxt[1] = WW'(9 * t2 - 10 * f_s);
    wg_nxt[2] = WW'(-9 * t2 + 8 * f_s + one_s);
    wg_nxt[3] = WW'(3 * t2 - 2 * f_s);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b_r <= 1'b0;
    end else begin
      v_b_r <= v_a_r;
    end
    o_b_r <= o_a_r;
    wq_r  <= wq_nxt;
    wg_r  <= wg_nxt;
  end

  // stage c: sixteen products, memory data arrives here
  logic signed [3:0][PW-1:0] pqx_r, pqy_r, pgx_r, pgy_r;
  logic v_c_r, o_c_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c_r <= 1'b0;
    end else begin
      v_c_r <= v_b_r && px_vld;
    end
    o_c_r <= o_b_r;
    for (int k = 0; k < 4; k++) begin
      pqx_r[k] <= PW'($signed(px[k])) * PW'($signed(wq_r[k]));
      pqy_r[k] <= PW'($signed(py[k])) * PW'($signed(wq_r[k]));
      pgx_r[k] <= PW'($signed(px[k])) * PW'($signed(wg_r[k]));
      pgy_r[k] <= PW'($signed(py[k])) * PW'($signed(wg_r[k]));
    end
  end

  // stage d: sums, rounding, saturation
  function automatic logic signed [SW-1:0] rnd(input logic signed [3:0][PW-1:0] p);
    logic signed [SW-1:0] s;
    s = SW'($signed(p[0])) + SW'($signed(p[1])) + SW'($signed(p[2])) +
        SW'($signed(p[3])) + (SW'(1) <<< FW);
    return s >>> (FW + 1);
  endfunction
  function automatic logic [crs_pkg::COORD_W-1:0] sat_c(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo;
    hi = SW'((64'sd1 <<< (crs_pkg::COORD_W - 1)) - 1);
    lo = -hi - 1;
    if (v > hi) return hi[crs_pkg::COORD_W-1:0];
    if (v < lo) return lo[crs_pkg::COORD_W-1:0];
    return v[crs_pkg::COORD_W-1:0];
  endfunction
  function automatic logic [crs_pkg::GRAD_W-1:0] sat_g(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo;
    hi = SW'((64'sd1 <<< (crs_pkg::GRAD_W - 1)) - 1);
    lo = -hi - 1;
    if (v > hi) return hi[crs_pkg::GRAD_W-1:0];
    if (v < lo) return lo[crs_pkg::GRAD_W-1:0];
    return v[crs_pkg::GRAD_W-1:0];
  endfunction

  crs_pkg::out_item_t res_nxt, res_r;
  logic v_d_r;
  always_comb begin
    res_nxt = '0;
    res_nxt.out_of_range = o_c_r;
    if (!o_c_r) begin
      res_nxt.pos_x  = sat_c(rnd(pqx_r));
      res_nxt.pos_y  = sat_c(rnd(pqy_r));
      res_nxt.grad_x = sat_g(rnd(pgx_r));
      res_nxt.grad_y = sat_g(rnd(pgy_r));
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_d_r <= 1'b0;
    end else begin
      v_d_r <= v_c_r;
    end
    res_r <= res_nxt;
  end
  assign out_vld  = v_d_r;
  assign out_item = res_r;
endmodule
`default_nettype wire

// ----- rtl/core/catmull_rom_spline_eval_top.sv -----
// top level of the catmull-rom spline evaluator: control, index logic, memory and blend
// depends on crs_pkg, crs_point_mem, crs_blend and the defines header
//
// One command is taken every clock cycle; busy never rises. A write command
// stores a control point and gives no result. An evaluate command gives
// exactly one result, shown with out_valid high for a single cycle once it
// has passed blend stages a to d; the receiver cannot stall it, so results
// are taken as they come. Each evaluate passes through the memory read and
// the weight, multiply and sum stages of the blend pipeline. A write is
// visible to an evaluate started in the next cycle or later.
`default_nettype none
`include "catmull_rom_spline_eval_top_defines.svh"
module catmull_rom_spline_eval_top #(
  parameter int MAX_POINTS  = 64,
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire crs_pkg::in_item_t             in_item,
  output      logic                          out_valid,
  output      crs_pkg::out_item_t            out_item,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [crs_pkg::NUM_W-1:0]     cfg_data
);
  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int BASE_W = crs_pkg::T_W - T_FRAC_BITS;
  localparam int CW     = (BASE_W > IDX_W ? BASE_W : IDX_W) + 2;

  // configuration registers
  logic [crs_pkg::NUM_W-1:0] num_r;
  logic                      loop_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r  <= crs_pkg::NUM_W'(4);
      loop_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crs_pkg::CFG_NUM_POINTS:  num_r  <= cfg_data;
        crs_pkg::CFG_LOOPED_MODE: loop_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic acc;
  assign acc = start && !busy;

  // effective count and segment index
  logic [CW-1:0] n, base, i0, i1, i2, i3, b1, b2;
  logic          oor;
  always_comb begin
    n = CW'(num_r);
    if (n < CW'(4)) n = CW'(4);
    if (n > CW'(MAX_POINTS)) n = CW'(MAX_POINTS);
    base = CW'(in_item.param_t[crs_pkg::T_W-1:T_FRAC_BITS]);
    b1 = base + CW'(1);
    b2 = base + CW'(2);
    if (loop_r) begin
      oor = base >= n;
      i1 = base;
      i0 = (base == '0) ? n - CW'(1) : base - CW'(1);
      i2 = (b1 >= n) ? b1 - n : b1;
      i3 = (b2 >= n) ? b2 - n : b2;
      if (i3 >= n) i3 = i3 - n;
    end else begin
      oor = (base + CW'(3)) >= n;
      i0 = base;
      i1 = b1;
      i2 = b2;
      i3 = base + CW'(3);
    end
  end

  logic [3:0][IDX_W-1:0] rd_idx;
  always_comb begin
    rd_idx[0] = i0[IDX_W-1:0];
    rd_idx[1] = i1[IDX_W-1:0];
    rd_idx[2] = i2[IDX_W-1:0];
    rd_idx[3] = i3[IDX_W-1:0];
    if (oor) rd_idx = '0;
  end

  logic wr_en;
  assign wr_en = acc && (in_item.command == crs_pkg::CMD_WRITE) &&
                 (int'(in_item.point_index) < MAX_POINTS);

  logic [3:0][crs_pkg::COORD_W-1:0] px, py;
  crs_point_mem #(.MAX_POINTS(MAX_POINTS), .IDX_W(IDX_W)) u_mem (
    .clk, .rst_n, .wr_en,
    .wr_idx (IDX_W'(in_item.point_index)),
    .wr_x   (in_item.point_x),
    .wr_y   (in_item.point_y),
    .rd_idx, .rd_x(px), .rd_y(py)
  );

  // memory data lands in the cycle after the read, alongside blend stage a
  logic ev, ev_a_r, ev_b_r;
  assign ev = acc && (in_item.command == crs_pkg::CMD_EVAL);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_a_r <= 1'b0;
      ev_b_r <= 1'b0;
    end else begin
      ev_a_r <= ev;
      ev_b_r <= ev_a_r;
    end
  end

  // realign memory data with stage b of the blend
  logic [3:0][crs_pkg::COORD_W-1:0] px_r, py_r;
  always_ff @(posedge clk) begin
    px_r <= px;
    py_r <= py;
  end

  crs_blend #(.T_FRAC_BITS(T_FRAC_BITS)) u_blend (
    .clk, .rst_n,
    .in_vld  (ev),
    .in_oor  (oor),
    .in_frac (in_item.param_t[T_FRAC_BITS-1:0]),
    .px      (px_r),
    .py      (py_r),
    .px_vld  (ev_b_r),
    .out_vld (out_valid),
    .out_item
  );

  `CRS_ASSERT(a_never_busy, !busy, "busy raised")
  `CRS_ASSERT_NEXT(a_eval_tracks, ev, ev_a_r, "evaluate lost in pipeline")
  `CRS_ASSERT(a_oor_zero, !out_valid || !out_item.out_of_range ||
              (out_item.pos_x == '0 && out_item.grad_y == '0), "flagged result not zero")
endmodule
`default_nettype wire
